[hw/rtl/qdk_pkg.sv]
// shared types, constants and the quadrature transition decode
// for the quadrature detent key block; no dependencies
package qdk_pkg;

    localparam int STEPS_W  = 7;
    localparam int ACCUM_W  = 8;
    localparam int KEY_W    = 8;
    localparam int TIME_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_DETENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_DIR      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_CW           = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_CCW          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BUTTON       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_US      = 3'd5;

    // register reset values
    localparam logic [STEPS_W-1:0] RST_STEPS_PER_DETENT = 7'd4;
    localparam logic [TIME_W-1:0]  RST_DEBOUNCE_US      = 32'd5000;

    // decoded step direction
    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_CW   = 2'sb01;
    localparam logic signed [1:0] DIR_CCW  = 2'sb11;

    typedef struct packed {
        logic             key_valid;
        logic [KEY_W-1:0] key_code;
    } t_key;

    typedef struct packed {
        logic              en;
        logic              level;
        logic [TIME_W-1:0] now_us;
    } t_btn_sample;

    // standard 16-entry quadrature transition table, index {prev_ab, cur_ab}
    function automatic logic signed [1:0] quad_dir(input logic [1:0] prev_ab,
                                                   input logic [1:0] cur_ab);
        logic signed [1:0] d;
        d = DIR_NONE;
        case ({prev_ab, cur_ab})
            4'd1, 4'd7, 4'd8, 4'd14:  d = DIR_CW;
            4'd2, 4'd4, 4'd11, 4'd13: d = DIR_CCW;
            default:                  d = DIR_NONE;
        endcase
        return d;
    endfunction

endpackage

[hw/rtl/qdk_in_if.sv]
// sample request channel: valid/ready plus pin levels and timestamp
// depends on qdk_pkg for field widths
interface qdk_in_if;
    logic                      valid;
    logic                      ready;
    logic                      a_level;
    logic                      b_level;
    logic                      button_level;
    logic [qdk_pkg::TIME_W-1:0] now_us;

    modport source (output valid, output a_level, output b_level,
                    output button_level, output now_us, input ready);
    modport sink   (input valid, input a_level, input b_level,
                    input button_level, input now_us, output ready);
endinterface

[hw/rtl/qdk_out_if.sv]
// key result channel: valid/ready plus key_valid and key_code
// depends on qdk_pkg for field widths
interface qdk_out_if;
    logic                      valid;
    logic                      ready;
    logic                      key_valid;
    logic [qdk_pkg::KEY_W-1:0] key_code;

    modport source (output valid, output key_valid, output key_code, input ready);
    modport sink   (input valid, input key_valid, input key_code, output ready);
endinterface

[hw/rtl/quadrature_detent_keys_with_debounce_top.sv]
// top level: config registers, quadrature step accumulation, key selection
// depends on qdk_pkg, qdk_in_if, qdk_out_if, qdk_debounce, qdk_skid

// Turns samples of an active-low quadrature encoder and push button into key
// events. Every accepted sample gives exactly one result, held in the output
// register, or in the skid register while results are stalled; one sample can
// be accepted every clock cycle while the skid is empty. The whole per-sample
// decode (transition table, accumulator add and compare, debounce compare)
// sits between the state registers and a two-entry result buffer, so the
// input side keeps taking requests while one finished result waits; ready
// drops only when both buffer entries are full. Registers are written through
// i_cfg_we / i_cfg_idx / i_cfg_data and should only change while no request
// is in flight; indexes beyond the register list are ignored.
module quadrature_detent_keys_with_debounce_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [qdk_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [qdk_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    qdk_in_if.sink                          i_sample,
    qdk_out_if.source                       o_key
);

    // configuration registers
    logic [qdk_pkg::STEPS_W-1:0] r_steps;
    logic                        r_reverse;
    logic [qdk_pkg::KEY_W-1:0]   r_key_cw;
    logic [qdk_pkg::KEY_W-1:0]   r_key_ccw;
    logic [qdk_pkg::KEY_W-1:0]   r_key_btn;
    logic [qdk_pkg::TIME_W-1:0]  r_window_us;

    // encoder state
    logic [1:0]                        r_prev_ab;
    logic signed [qdk_pkg::ACCUM_W-1:0] r_accum;
    logic signed [qdk_pkg::ACCUM_W-1:0] n_accum;

    logic                                take;
    logic                                buf_full;
    logic [1:0]                          cur_ab;
    logic                                changed;
    logic signed [1:0]                   dir_raw;
    logic signed [1:0]                   dir;
    logic                                step;
    logic signed [qdk_pkg::ACCUM_W:0]    sum;
    logic signed [qdk_pkg::ACCUM_W:0]    spd;
    logic signed [qdk_pkg::ACCUM_W:0]    neg_spd;
    logic                                hit_cw;
    logic                                hit_ccw;
    logic                                detent;
    logic                                press;
    qdk_pkg::t_btn_sample                btn;
    qdk_pkg::t_key                       result;

    assign i_sample.ready = !buf_full;
    assign take           = i_sample.valid && !buf_full;

    // config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps     <= qdk_pkg::RST_STEPS_PER_DETENT;
            r_reverse   <= 1'b0;
            r_key_cw    <= '0;
            r_key_ccw   <= '0;
            r_key_btn   <= '0;
            r_window_us <= qdk_pkg::RST_DEBOUNCE_US;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qdk_pkg::CFG_STEPS_PER_DETENT: r_steps     <= i_cfg_data[qdk_pkg::STEPS_W-1:0];
                qdk_pkg::CFG_REVERSE_DIR:      r_reverse   <= i_cfg_data[0];
                qdk_pkg::CFG_KEY_CW:           r_key_cw    <= i_cfg_data[qdk_pkg::KEY_W-1:0];
                qdk_pkg::CFG_KEY_CCW:          r_key_ccw   <= i_cfg_data[qdk_pkg::KEY_W-1:0];
                qdk_pkg::CFG_KEY_BUTTON:       r_key_btn   <= i_cfg_data[qdk_pkg::KEY_W-1:0];
                qdk_pkg::CFG_DEBOUNCE_US:      r_window_us <= i_cfg_data[qdk_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // pins are active low: invert into {a, b}
    assign cur_ab  = {~i_sample.a_level, ~i_sample.b_level};
    assign changed = (cur_ab != r_prev_ab);
    assign dir_raw = qdk_pkg::quad_dir(r_prev_ab, cur_ab);
    assign dir     = r_reverse ? (~dir_raw + 2'sb01) : dir_raw;
    assign step    = changed && (dir_raw != qdk_pkg::DIR_NONE);

    // accumulator with one guard bit for the compare against +/- steps
    assign sum     = $signed({r_accum[qdk_pkg::ACCUM_W-1], r_accum})
                   + $signed({{(qdk_pkg::ACCUM_W-1){dir[1]}}, dir});
    assign spd     = $signed({{(qdk_pkg::ACCUM_W+1-qdk_pkg::STEPS_W){1'b0}}, r_steps});
    assign neg_spd = -spd;
    assign hit_cw  = step && (sum >= spd);
    assign hit_ccw = step && !hit_cw && (sum <= neg_spd);
    assign detent  = hit_cw || hit_ccw;

    always_comb begin
        n_accum = r_accum;
        if (changed) begin
            if (!step || detent) begin
                // illegal two-pin jump or a completed detent
                n_accum = '0;
            end else begin
                n_accum = sum[qdk_pkg::ACCUM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ab <= 2'b00;
            r_accum   <= '0;
        end else if (take) begin
            r_prev_ab <= cur_ab;
            r_accum   <= n_accum;
        end
    end

    // button is left alone on a sample that fires a detent
    assign btn.en     = take && !detent;
    assign btn.level  = i_sample.button_level;
    assign btn.now_us = i_sample.now_us;

    qdk_debounce u_debounce (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (btn),
        .i_window_us (r_window_us),
        .o_press     (press)
    );

    // one result per sample, key_code zero when no event
    always_comb begin
        result.key_valid = 1'b0;
        result.key_code  = '0;
        if (hit_cw) begin
            result.key_valid = 1'b1;
            result.key_code  = r_key_cw;
        end else if (hit_ccw) begin
            result.key_valid = 1'b1;
            result.key_code  = r_key_ccw;
        end else if (press) begin
            result.key_valid = 1'b1;
            result.key_code  = r_key_btn;
        end
    end

    qdk_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (result),
        .o_full  (buf_full),
        .o_key   (o_key)
    );

endmodule

[hw/rtl/qdk_debounce.sv]
// first-edge-latch button debouncer with wrapping time difference
// depends on qdk_pkg
module qdk_debounce (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  qdk_pkg::t_btn_sample        i_sample,
    input  logic [qdk_pkg::TIME_W-1:0]  i_window_us,
    output logic                        o_press
);

    logic                       r_stable;
    logic                       r_held;
    logic                       r_open;
    logic [qdk_pkg::TIME_W-1:0] r_start;

    logic                       n_stable;
    logic                       n_held;
    logic                       n_open;
    logic [qdk_pkg::TIME_W-1:0] n_start;
    logic [qdk_pkg::TIME_W-1:0] elapsed;
    logic                       commit;

    assign elapsed = i_sample.now_us - r_start;
    assign commit  = (i_sample.level != r_stable) && r_open && (elapsed >= i_window_us);
    assign o_press = i_sample.en && commit && !i_sample.level && !r_held;

    always_comb begin
        n_stable = r_stable;
        n_held   = r_held;
        n_open   = r_open;
        n_start  = r_start;
        if (i_sample.level != r_stable) begin
            if (!r_open) begin
                n_start = i_sample.now_us;
                n_open  = 1'b1;
            end else if (commit) begin
                n_stable = i_sample.level;
                n_open   = 1'b0;
                if (!i_sample.level && !r_held) begin
                    n_held = 1'b1;
                end else if (i_sample.level && r_held) begin
                    n_held = 1'b0;
                end
            end
        end else begin
            n_open = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b1;
            r_held   <= 1'b0;
            r_open   <= 1'b0;
            r_start  <= '0;
        end else if (i_sample.en) begin
            r_stable <= n_stable;
            r_held   <= n_held;
            r_open   <= n_open;
            r_start  <= n_start;
        end
    end

endmodule

[hw/rtl/qdk_skid.sv]
// two-entry result buffer: output register plus skid register
// depends on qdk_pkg and qdk_out_if
module qdk_skid (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qdk_pkg::t_key i_data,
    output logic          o_full,
    qdk_out_if.source     o_key
);

    logic          r_out_v;
    logic          r_skid_v;
    qdk_pkg::t_key r_out;
    qdk_pkg::t_key r_skid;
    logic          pop;

    assign pop             = r_out_v && o_key.ready;
    assign o_full          = r_skid_v;
    assign o_key.valid     = r_out_v;
    assign o_key.key_valid = r_out.key_valid;
    assign o_key.key_code  = r_out.key_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (pop) begin
                r_skid_v <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_v && !pop) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (pop) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_v && !pop) begin
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end
    end

endmodule

[hw/rtl/qdk_checker.sv]
// port-level checks for the quadrature detent key block, bound to the top
// depends on quadrature_detent_keys_with_debounce_top
module qdk_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic                      i_key_valid,
    input logic [qdk_pkg::KEY_W-1:0] i_key_code
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_key_valid) && $stable(i_key_code))
        else $error("stalled result changed");

    // no event means a zero keycode
    a_zero_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_key_valid |-> i_key_code == '0)
        else $error("nonzero keycode without key event");

    // reset empties the result buffer
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // input only stalls when a result is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with empty result buffer");

    // a full buffer only drains when the sink takes a result
    a_full_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready && !i_out_ready |=> !i_in_ready)
        else $error("buffer drained without a taken result");

endmodule

bind quadrature_detent_keys_with_debounce_top qdk_checker u_qdk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_key.valid),
    .i_out_ready (o_key.ready),
    .i_key_valid (o_key.key_valid),
    .i_key_code  (o_key.key_code)
);
